// ===== rtl/ordered_array_insert_delete_search_unit_defines.svh =====
// Assertion macros for the ordered array unit.
// Included by RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_UNIT_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define OAIDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a trigger in one cycle is followed by an outcome in the next.
`define OAIDS_ASSERT_NEXT(lbl, trig, outcome, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (outcome)) \
    else $error(msg);

`endif

// ===== rtl/oaids_pkg.sv =====
// Shared constants, codes and types for the ordered array unit.
// No dependencies; imported by the cell, the match encoder and the top level.
package oaids_pkg;

  // List geometry
  localparam int DEPTH    = 128;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;

  // Port field widths
  localparam int OP_W        = 3;
  localparam int POS_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int FOUND_W     = 7;
  localparam int COUNT_OUT_W = 8;

  // Width that holds both a position and a count for compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // First-match encoder grouping
  localparam int GRP   = 8;
  localparam int GRP_W = $clog2(GRP);
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [OP_W-1:0] {
    OP_INS_POS = 3'd0,
    OP_INS_KEY = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_DEL_POS = 3'd3,
    OP_DEL_KEY = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOKEY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_INS  = 2'd1,
    ACT_DEL  = 2'd2
  } act_e;

  // Update command broadcast to every cell of the chain
  typedef struct packed {
    act_e              act;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_upd_t;

endpackage

// ===== rtl/oaids_cell.sv =====
// One list slot: holds an entry, compares it with the key and shifts with its neighbors.
// Depends on oaids_pkg for widths and the update command type.
module oaids_cell
  import oaids_pkg::*;
(
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              cmp_en_i,
  input  logic [DATA_W-1:0] key_i,
  input  cell_upd_t         upd_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] entry_o,
  output logic              match_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              match_q;
  logic              live;

  // Only slots below the count hold list entries
  assign live = CNT_W'(idx_i) < count_i;

  // Pick the next entry: hold, take the new value, or shift from a neighbor
  always_comb begin
    entry_d = entry_q;
    case (upd_i.act)
      ACT_INS: begin
        if (idx_i == upd_i.pos) begin
          entry_d = upd_i.value;
        end else if (idx_i > upd_i.pos) begin
          entry_d = left_i;
        end
      end
      ACT_DEL: begin
        if (idx_i >= upd_i.pos) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Capture the key compare for the match encoder
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      match_q <= live && (entry_q == key_i);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== rtl/oaids_first_match.sv =====
// Two-level first-match encoder over the cell match flags.
// Depends on oaids_pkg; the group level is registered, the final pick is combinational.
module oaids_first_match
  import oaids_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEPTH-1:0] match_i,
  output logic             hit_o,
  output logic [IDX_W-1:0] idx_o
);

  logic [NGRP*GRP-1:0] match_pad;
  logic [NGRP-1:0]     grp_any_d, grp_any_q;
  logic [GRP_W-1:0]    grp_idx_d [NGRP];
  logic [GRP_W-1:0]    grp_idx_q [NGRP];

  assign match_pad = (NGRP*GRP)'(match_i);

  // Find the lowest set flag inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if (match_pad[g*GRP + k]) begin
          grp_any_d[g] = 1'b1;
          grp_idx_d[g] = GRP_W'(k);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_any_q <= grp_any_d;
      for (int g = 0; g < NGRP; g++) begin
        grp_idx_q[g] <= grp_idx_d[g];
      end
    end
  end

  // Pick the lowest group with a hit
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        hit_o = 1'b1;
        idx_o = IDX_W'(g * GRP + int'(grp_idx_q[g]));
      end
    end
  end

endmodule

// ===== rtl/ordered_array_insert_delete_search_unit.sv =====
// Channel | direction | handshake              | payload
// in      | into unit | in_valid_i / in_stall_o | op_i, position_i, key_i, new_value_i
// out     | from unit | out_valid_o / out_stall_i | status_o, found_index_o, entry_count_o
//
// After the accepting edge the result register loads through these steps: key compare in every
// cell, group encode, first-match pick and plan, then the chain shift.
// The next beat is taken once the shift step is done, so a new beat never enters before the
// last one is through; the result register lets it start while the previous result still waits.
// A stalled result holds the shift step until the result register frees up.
// Reset clears the count and control state; entry contents are left as they are.
// Top level of the ordered array unit; depends on oaids_pkg, oaids_cell,
// oaids_first_match and the assertion macro header.
`include "ordered_array_insert_delete_search_unit_defines.svh"

module ordered_array_insert_delete_search_unit
  import oaids_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] key_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [FOUND_W-1:0]       found_index_o,
  output logic [COUNT_OUT_W-1:0]   entry_count_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_GRP  = 5'b00100,
    S_SEL  = 5'b01000,
    S_UPD  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  count_q, count_d;

  logic in_fire, upd_fire;

  // Plan computed from the match result
  act_e             plan_act_d, plan_act_q;
  logic [IDX_W-1:0] plan_pos_d, plan_pos_q;
  status_e          plan_status_d, plan_status_q;
  logic [FOUND_W-1:0] plan_found_d, plan_found_q;

  // Result register
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [FOUND_W-1:0]     found_q;
  logic [COUNT_OUT_W-1:0] count_out_q;

  // Chain wiring
  logic [DATA_W-1:0] entry_w [DEPTH];
  logic [DATA_W-1:0] left_w  [DEPTH];
  logic [DATA_W-1:0] right_w [DEPTH];
  logic [DEPTH-1:0]  match_w;
  cell_upd_t         upd;

  logic             fm_hit;
  logic [IDX_W-1:0] fm_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign upd_fire   = (state_q == S_UPD) && (!out_valid_q || !out_stall_i);

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_CMP;
      S_CMP:  state_d = S_GRP;
      S_GRP:  state_d = S_SEL;
      S_SEL:  state_d = S_UPD;
      S_UPD:  if (upd_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_i;
      pos_q <= position_i;
      key_q <= key_i;
      val_q <= new_value_i;
    end
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i] = '0;
    end else begin : g_body
      assign left_w[i] = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w[i] = '0;
    end else begin : g_inner
      assign right_w[i] = entry_w[i+1];
    end

    oaids_cell u_cell (
      .clk_i    (clk_i),
      .idx_i    (IDX_W'(i)),
      .count_i  (count_q),
      .cmp_en_i (state_q == S_CMP),
      .key_i    (key_q),
      .upd_i    (upd),
      .left_i   (left_w[i]),
      .right_i  (right_w[i]),
      .entry_o  (entry_w[i]),
      .match_o  (match_w[i])
    );
  end

  oaids_first_match u_first_match (
    .clk_i   (clk_i),
    .en_i    (state_q == S_GRP),
    .match_i (match_w),
    .hit_o   (fm_hit),
    .idx_o   (fm_idx)
  );

  // Decide status, action and target slot
  always_comb begin
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CNT_W-1:0] ins_pos;
    logic             full;

    pos_cmp = CMP_W'(pos_q);
    cnt_cmp = CMP_W'(count_q);
    full    = (count_q == CNT_W'(DEPTH));
    ins_pos = (pos_cmp > cnt_cmp) ? count_q : CNT_W'(pos_q);

    plan_act_d    = ACT_NONE;
    plan_pos_d    = '0;
    plan_status_d = ST_OK;
    plan_found_d  = '0;

    case (op_e'(op_q))
      OP_INS_POS: begin
        if (full) begin
          plan_status_d = ST_FULL;
        end else begin
          plan_act_d = ACT_INS;
          plan_pos_d = IDX_W'(ins_pos);
        end
      end
      OP_INS_KEY: begin
        if (full) begin
          plan_status_d = ST_FULL;
        end else if (fm_hit) begin
          plan_act_d = ACT_INS;
          plan_pos_d = IDX_W'(CNT_W'(fm_idx) + CNT_W'(1));
        end else begin
          // Missing key: insert at the front
          plan_status_d = ST_NOKEY;
          plan_act_d    = ACT_INS;
        end
      end
      OP_SEARCH: begin
        if (fm_hit) begin
          plan_found_d = FOUND_W'(fm_idx);
        end else begin
          plan_status_d = ST_NOKEY;
        end
      end
      OP_DEL_POS: begin
        if (pos_cmp >= cnt_cmp) begin
          plan_status_d = ST_RANGE;
        end else begin
          plan_act_d = ACT_DEL;
          plan_pos_d = IDX_W'(pos_q);
        end
      end
      OP_DEL_KEY: begin
        if (fm_hit) begin
          plan_act_d = ACT_DEL;
          plan_pos_d = fm_idx;
        end else begin
          plan_status_d = ST_NOKEY;
        end
      end
      default: begin
        plan_act_d = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SEL) begin
      plan_act_q    <= plan_act_d;
      plan_pos_q    <= plan_pos_d;
      plan_status_q <= plan_status_d;
      plan_found_q  <= plan_found_d;
    end
  end

  // Broadcast the shift command on the update step only
  assign upd.act   = upd_fire ? plan_act_q : ACT_NONE;
  assign upd.pos   = plan_pos_q;
  assign upd.value = val_q;

  // Track the entry count
  always_comb begin
    count_d = count_q;
    case (plan_act_q)
      ACT_INS: count_d = count_q + CNT_W'(1);
      ACT_DEL: count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (upd_fire) begin
      count_q <= count_d;
    end
  end

  // Load the result register; drop valid once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      status_q    <= plan_status_q;
      found_q     <= plan_found_q;
      count_out_q <= COUNT_OUT_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign entry_count_o = count_out_q;

  // Checks
  `OAIDS_ASSERT(a_count_bound, (count_q <= CNT_W'(DEPTH)), "entry count above depth")
  `OAIDS_ASSERT_NEXT(a_ins_grows, (upd_fire && plan_act_q == ACT_INS),
    (count_q == $past(count_q) + CNT_W'(1)), "insert did not grow the count")
  `OAIDS_ASSERT_NEXT(a_fail_holds, (upd_fire && plan_status_q != ST_OK && plan_act_q == ACT_NONE),
    (count_q == $past(count_q)), "failed operation changed the count")
  `OAIDS_ASSERT(a_found_search, ((state_q == S_UPD && plan_found_q != '0) |-> (op_q == OP_SEARCH)),
    "found index set for an operation other than search")

endmodule
